// ===== hdl/pea_pkg.sv =====
// Package: shared constants and types for the photon efficiency acceptance block.
package pea_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int WlW = 16;
  localparam int EffW = 17;
  localparam int RndW = 16;
  localparam int TagW = 32;
  localparam int NumW = 34;
  localparam int DenW = 17;
  localparam int CfgW = 5;
  localparam logic [EffW-1:0] OneFixed = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_ABOVE = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_PHOTON = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DONE
  } state_t;

  // Token carried down the scan row: best low and high so far.
  typedef struct packed {
    logic            lv;
    logic            hv;
    logic [WlW-1:0]  wl;
    logic [EffW-1:0] el;
    logic [WlW-1:0]  wh;
    logic [EffW-1:0] eh;
  } scan_tok_t;

  // Input item.
  typedef struct packed {
    logic            kind;
    logic [3:0]      entry_index;
    logic [WlW-1:0]  entry_wavelength;
    logic [EffW-1:0] entry_efficiency;
    logic [WlW-1:0]  photon_wavelength;
    logic [RndW-1:0] random_value;
    logic [TagW-1:0] hit_tag;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic            accepted;
    logic [1:0]      status;
    logic [EffW-1:0] efficiency_used;
    logic [TagW-1:0] tag_out;
  } out_item_t;

endpackage

// ===== hdl/pea_if.sv =====
// Interfaces: valid/ready channels for input and result items.
interface pea_in_if import pea_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pea_out_if import pea_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/photon_efficiency_acceptance.sv =====
// Top level: table of scan cells, weighted-mean divider and result register.
// Load item: written into its table entry, no result.
// Photon item: table scan, multiply setup, divide and finishing steps, in that order;
// the divide is skipped on range errors or zero weight.
// Input is not taken while a photon is in work or its result waits, so output stalls hold input too.
// Reset (rst, synchronous) clears entries_in_use and control; table is not cleared.
module photon_efficiency_acceptance import pea_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_wdata,
  pea_in_if.sink          in_ch,
  pea_out_if.source       out_ch
);

  state_t          state, state_next;
  logic [CfgW-1:0] entries_in_use;
  logic [CntW-1:0] n_used;
  logic [IdxW-1:0] pos;
  logic [WlW-1:0]  photon;
  logic [RndW-1:0] rnd;
  logic [TagW-1:0] tag;
  scan_tok_t       tok;
  scan_tok_t       cell_out [TableDepth];
  scan_tok_t       tok_sel;
  logic            mul_phase;
  logic [NumW-1:0] prod_l, prod_h;
  logic            div_start, div_busy, div_rem_nz;
  logic [NumW-1:0] div_quo, num;
  logic [DenW-1:0] den;
  out_item_t       res;
  out_item_t       res_next;
  logic            res_valid;
  logic            in_fire, photon_fire, last_pos;
  logic [EffW:0]   half_sum;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign photon_fire = in_fire && (in_ch.data.kind == KIND_PHOTON);
  assign in_ch.ready = (state == S_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;
  assign last_pos    = (pos == IdxW'(TableDepth - 1));

  // Clamp entry count to the table depth
  always_comb begin
    if (entries_in_use > CfgW'(TableDepth)) n_used = CntW'(TableDepth);
    else n_used = CntW'(entries_in_use);
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) entries_in_use <= '0;
    else if (cfg_we) entries_in_use <= cfg_wdata;
  end

  // Row of cells; token passes one cell per cycle, the active cell is pos
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    pea_cell u_cell (
      .clk    (clk),
      .wr     (in_fire && in_ch.data.kind == KIND_LOAD
               && {1'b0, in_ch.data.entry_index} < 5'(TableDepth)
               && in_ch.data.entry_index[IdxW-1:0] == IdxW'(g)),
      .wr_wl  (in_ch.data.entry_wavelength),
      .wr_eff (in_ch.data.entry_efficiency),
      .active (state == S_SCAN && pos == IdxW'(g) && CntW'(g) < n_used),
      .photon (photon),
      .tok_in (tok),
      .tok_out(cell_out[g])
    );
  end
  assign tok_sel = cell_out[pos];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (photon_fire) state_next = S_SCAN;
      S_SCAN:  if (last_pos) state_next = S_DIV;
      S_DIV:   if (!mul_phase && !div_start && !div_busy) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Divider operands
  assign num = prod_l + prod_h;
  assign den = DenW'({1'b0, tok.wl} + {1'b0, tok.wh});
  assign half_sum = ({1'b0, tok.el} + {1'b0, tok.eh});

  // Result item from the final token and the quotient
  always_comb begin
    res_next = '0;
    res_next.tag_out = tag;
    if (!tok.lv) begin
      res_next.status = ST_BELOW;
    end else if (!tok.hv) begin
      res_next.status = ST_ABOVE;
    end else if (den == '0) begin
      res_next.efficiency_used = half_sum[EffW:1];
      if (half_sum[EffW:1] > OneFixed) begin
        res_next.status = ST_OVER;
      end else begin
        res_next.status   = ST_OK;
        res_next.accepted = (half_sum[EffW:1] >= {1'b0, rnd});
      end
    end else begin
      res_next.efficiency_used = div_quo[EffW-1:0];
      if (div_quo > NumW'(OneFixed) || (div_quo == NumW'(OneFixed) && div_rem_nz))
      begin
        res_next.status = ST_OVER;
      end else begin
        res_next.status   = ST_OK;
        res_next.accepted = (div_quo[EffW-1:0] >= {1'b0, rnd});
      end
    end
  end

  // Scan, multiply, divide sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      mul_phase <= 1'b0;
      div_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      div_start <= (state == S_DIV) && mul_phase && tok.lv && tok.hv && (den != '0);
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (photon_fire) begin
            photon <= in_ch.data.photon_wavelength;
            rnd    <= in_ch.data.random_value;
            tag    <= in_ch.data.hit_tag;
            tok    <= '0;
            pos    <= '0;
          end
        end
        S_SCAN: begin
          tok <= tok_sel;
          pos <= pos + 1'b1;
          if (last_pos) mul_phase <= 1'b1;
        end
        S_DIV: begin
          if (mul_phase) begin
            prod_l    <= NumW'(tok.wl) * NumW'(tok.el);
            prod_h    <= NumW'(tok.wh) * NumW'(tok.eh);
            mul_phase <= 1'b0;
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          res       <= res_next;
        end
        default: ;
      endcase
    end
  end

  pea_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem_nz(div_rem_nz)
  );

endmodule

// ===== hdl/pea_cell.sv =====
// Scan cell: holds one table entry and updates the passing low/high token.
module pea_cell import pea_pkg::*; (
  input  logic            clk,
  input  logic            wr,
  input  logic [WlW-1:0]  wr_wl,
  input  logic [EffW-1:0] wr_eff,
  input  logic            active,
  input  logic [WlW-1:0]  photon,
  input  scan_tok_t       tok_in,
  output scan_tok_t       tok_out
);

  logic [WlW-1:0]  wl;
  logic [EffW-1:0] eff;

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      wl  <= wr_wl;
      eff <= wr_eff;
    end
  end

  // Low takes priority over high, as in the scan rule
  always_comb begin
    tok_out = tok_in;
    if (active) begin
      if (wl <= photon && (!tok_in.lv || tok_in.wl < wl)) begin
        tok_out.lv = 1'b1;
        tok_out.wl = wl;
        tok_out.el = eff;
      end else if (photon <= wl && (!tok_in.hv || wl < tok_in.wh)) begin
        tok_out.hv = 1'b1;
        tok_out.wh = wl;
        tok_out.eh = eff;
      end
    end
  end

endmodule

// ===== hdl/pea_div.sv =====
// Sequential restoring divider: 34-bit numerator by 17-bit divisor.
module pea_div import pea_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quo,
  output logic            rem_nz
);

  localparam int StepW = $clog2(NumW + 1);

  logic [DenW:0]    rem;
  logic [DenW-1:0]  dvs;
  logic [StepW-1:0] steps;
  logic [DenW+1:0]  trial;
  logic [DenW:0]    shifted;

  assign shifted = {rem[DenW-1:0], quo[NumW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};
  assign rem_nz  = (rem != '0);

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= StepW'(NumW);
      quo   <= num;
      rem   <= '0;
      dvs   <= den;
    end else if (busy) begin
      if (!trial[DenW+1]) begin
        rem <= trial[DenW:0];
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[NumW-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
      busy  <= (steps != StepW'(1));
    end
  end

endmodule

// ===== hdl/pea_checker.sv =====
// Checker: port-level properties of the photon efficiency acceptance block.
module pea_checker import pea_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result never shows up while input is being taken
  a_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");

  // Load item leaves the block ready next cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.kind == KIND_LOAD) |=> in_ready)
    else $error("load stalled input");

  // Photon item blocks input next cycle
  a_photon: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.kind == KIND_PHOTON) |=> !in_ready)
    else $error("photon did not start work");

  // Range errors report zero efficiency and no acceptance
  a_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_BELOW || out_data.status == ST_ABOVE))
    |-> (out_data.efficiency_used == '0 && !out_data.accepted))
    else $error("range error with nonzero efficiency");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

endmodule

bind photon_efficiency_acceptance pea_checker u_pea_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_data  (in_ch.data),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);
